### rtl/core/src_pkg.sv
// Shared types, constants and arithmetic helpers of the spectral response calibrator.
package src_pkg;

  localparam int unsigned BIN_W       = 19;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ACT_W       = 20;
  localparam int unsigned FRAC_W      = 24;
  localparam int unsigned QUOT_STEPS  = 31;
  localparam int unsigned MLO_W       = QUOT_STEPS - FRAC_W;
  localparam int unsigned DIV_LAT     = QUOT_STEPS + 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned ADDR_W      = 4;

  localparam logic signed [64:0] ONE_Q24  = 65'sd16777216;
  localparam logic signed [64:0] HALF_LSB = 65'sd8388608;
  localparam logic signed [64:0] HALF_DN  = 65'sd8388607;
  localparam logic signed [64:0] SAT_HI   = 65'sd2147483647;
  localparam logic signed [64:0] SAT_LO   = -65'sd2147483648;
  localparam logic signed [31:0] MAX_Q24  = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_Q24  = 32'sh80000000;

  typedef enum logic {
    OP_LOAD      = 1'b0,
    OP_CALIBRATE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_ACTIVE    = 2'd1,
    REG_ALPHA     = 2'd2,
    REG_ALPHABETA = 2'd3
  } reg_e;

  typedef struct packed {
    logic                     operation;
    logic [BIN_W-1:0]         bin_index;
    logic signed [DATA_W-1:0] sensing_re;
    logic signed [DATA_W-1:0] sensing_im;
    logic signed [DATA_W-1:0] openloop_re;
    logic signed [DATA_W-1:0] openloop_im;
    logic signed [DATA_W-1:0] bin_re;
    logic signed [DATA_W-1:0] bin_im;
  } cmd_t;

  typedef struct packed {
    logic [BIN_W-1:0]         result_bin;
    logic signed [DATA_W-1:0] out_re;
    logic signed [DATA_W-1:0] out_im;
    logic                     zero_denominator;
  } result_t;

  // One classified calibrate word handed from front to back.
  typedef struct packed {
    logic                     calibrate;
    logic [BIN_W-1:0]         bin;
    logic signed [DATA_W-1:0] yr;
    logic signed [DATA_W-1:0] yi;
    logic signed [DATA_W-1:0] cr;
    logic signed [DATA_W-1:0] ci;
    logic signed [DATA_W-1:0] hr;
    logic signed [DATA_W-1:0] hi;
  } work_t;

  typedef struct packed {
    logic valid;
    logic near_full;
  } queue_status_t;

  // Round by 2^24 to nearest, ties away from zero.
  function automatic logic signed [64:0] rnd24(input logic signed [64:0] p);
    logic signed [64:0] b;
    b = p + (p[64] ? HALF_DN : HALF_LSB);
    return b >>> FRAC_W;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = MAX_Q24;
    else if (v < SAT_LO) r = MIN_Q24;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/core/spectral_response_calibrator_unit.sv
// Top level of the spectral response calibrator: register port, front, queue and back.
//
// The block takes one word per clock while busy is low: a load word writes a bin's
// sensing and open-loop entries into the per-bin table, a calibrate word multiplies
// its spectrum bin by (alphabeta*H + 1) / (alpha*C) and returns one result word on
// result_valid_o. Results come out in acceptance order, through the table read and
// queue stages, the 31-step quotient pipeline with its entry and exit registers, and
// the multiply stages around it. The receiver cannot stall, and busy stays low in
// normal use: the back part drains the queue at one word per cycle. Bins at or
// above active_bins, or all bins while calibration is disabled, pass through
// unchanged. A zero scaled sensing magnitude yields a zero result with
// zero_denominator set. Table entries hold no reset value; calibrate only bins that
// were loaded (bins beyond the table depth read as zero and flag a zero denominator).
// Write registers only while idle.
module spectral_response_calibrator_unit #(
  parameter int unsigned BIN_DEPTH = 524288
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Item handshake
  input  logic                              start,
  output logic                              busy,
  input  src_pkg::cmd_t                     cmd_i,
  output logic                              result_valid_o,
  output src_pkg::result_t                  result_o,
  // Register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [src_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic                               cal_enable_q;
  logic [src_pkg::ACT_W-1:0]          active_bins_q;
  logic signed [src_pkg::DATA_W-1:0]  alpha_q;
  logic signed [src_pkg::DATA_W-1:0]  alphabeta_q;
  logic                               reg_wr;
  src_pkg::reg_e                      reg_sel;

  logic                               accept;
  logic                               push;
  src_pkg::work_t                     front_work;
  src_pkg::work_t                     back_work;
  src_pkg::queue_status_t             q_status;

  // Register file: writes land on the access phase, reads return the stored value.
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = src_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_enable_q  <= 1'b0;
      active_bins_q <= '0;
      alpha_q       <= 32'sd16777216;
      alphabeta_q   <= 32'sd16777216;
    end else if (reg_wr) begin
      unique case (reg_sel)
        src_pkg::REG_ENABLE:    cal_enable_q  <= pwdata[0];
        src_pkg::REG_ACTIVE:    active_bins_q <= pwdata[src_pkg::ACT_W-1:0];
        src_pkg::REG_ALPHA:     alpha_q       <= pwdata;
        src_pkg::REG_ALPHABETA: alphabeta_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      src_pkg::REG_ENABLE:    prdata = 32'(cal_enable_q);
      src_pkg::REG_ACTIVE:    prdata = 32'(active_bins_q);
      src_pkg::REG_ALPHA:     prdata = alpha_q;
      src_pkg::REG_ALPHABETA: prdata = alphabeta_q;
      default:                prdata = '0;
    endcase
  end

  // Hold off new words only if the queue backs up.
  assign busy   = q_status.near_full;
  assign accept = start && !busy;

  src_front #(
    .BIN_DEPTH (BIN_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .cmd_i         (cmd_i),
    .cal_enable_i  (cal_enable_q),
    .active_bins_i (active_bins_q),
    .push_o        (push),
    .work_o        (front_work)
  );

  // Drain one word per cycle into the back part.
  src_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .work_i   (front_work),
    .pop_i    (q_status.valid),
    .status_o (q_status),
    .work_o   (back_work)
  );

  src_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_status.valid),
    .work_i         (back_work),
    .alpha_i        (alpha_q),
    .alphabeta_i    (alphabeta_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

`ifndef SYNTHESIS
  // The back part never stalls, so the queue must never fill up.
  a_no_backup: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("calibrator queue backed up");

  // A zero denominator always comes with a zeroed bin.
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.zero_denominator |->
      (result_o.out_re == '0) && (result_o.out_im == '0))
    else $error("zero denominator with nonzero result");

  // With calibration off every result is a pass-through.
  a_pass_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !cal_enable_q |-> !result_o.zero_denominator)
    else $error("flag raised while calibration disabled");
`endif

endmodule

### rtl/core/src_front.sv
// Front part: accepts items, writes the response tables and classifies calibrate words.
module src_front #(
  parameter int unsigned BIN_DEPTH = 524288
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  src_pkg::cmd_t                 cmd_i,
  input  logic                          cal_enable_i,
  input  logic [src_pkg::ACT_W-1:0]     active_bins_i,
  output logic                          push_o,
  output src_pkg::work_t                work_o
);

  localparam int unsigned AW  = $clog2(BIN_DEPTH);
  localparam int unsigned XW  = (AW > src_pkg::BIN_W) ? AW : src_pkg::BIN_W;
  localparam int unsigned XW1 = XW + 1;

  logic [XW-1:0]  bin_x;
  logic [AW-1:0]  addr;
  logic           in_table;
  logic           is_load;
  logic [127:0]   tbl_mem [BIN_DEPTH];
  logic [127:0]   rd_q;

  logic           s1_valid_q, s1_valid_d;
  logic           s1_cal_q;
  logic           s1_in_table_q;
  logic [src_pkg::BIN_W-1:0]         s1_bin_q;
  logic signed [src_pkg::DATA_W-1:0] s1_yr_q, s1_yi_q;

  assign bin_x    = XW'(cmd_i.bin_index);
  assign addr     = bin_x[AW-1:0];
  assign in_table = {1'b0, bin_x} < XW1'(BIN_DEPTH);
  assign is_load  = (cmd_i.operation == src_pkg::OP_LOAD);
  assign s1_valid_d = accept_i && !is_load;

  // Table word: sensing re, sensing im, open-loop re, open-loop im from low to high.
  always_ff @(posedge clk_i) begin
    if (accept_i && is_load && in_table) begin
      tbl_mem[addr] <= {cmd_i.openloop_im, cmd_i.openloop_re,
                        cmd_i.sensing_im, cmd_i.sensing_re};
    end
    rd_q <= tbl_mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cal_q      <= cal_enable_i && ({1'b0, cmd_i.bin_index} < active_bins_i);
    s1_in_table_q <= in_table;
    s1_bin_q      <= cmd_i.bin_index;
    s1_yr_q       <= cmd_i.bin_re;
    s1_yi_q       <= cmd_i.bin_im;
  end

  // Bins beyond the table read as zero entries.
  always_comb begin
    push_o           = s1_valid_q;
    work_o.calibrate = s1_cal_q;
    work_o.bin       = s1_bin_q;
    work_o.yr        = s1_yr_q;
    work_o.yi        = s1_yi_q;
    work_o.cr        = s1_in_table_q ? rd_q[31:0]   : '0;
    work_o.ci        = s1_in_table_q ? rd_q[63:32]  : '0;
    work_o.hr        = s1_in_table_q ? rd_q[95:64]  : '0;
    work_o.hi        = s1_in_table_q ? rd_q[127:96] : '0;
  end

endmodule

### rtl/core/src_queue.sv
// Short queue of classified words between the front and back parts.
module src_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  src_pkg::work_t          work_i,
  input  logic                    pop_i,
  output src_pkg::queue_status_t  status_o,
  output src_pkg::work_t          work_o
);

  localparam int unsigned QW = $clog2(src_pkg::QUEUE_DEPTH);

  src_pkg::work_t   buf_q [src_pkg::QUEUE_DEPTH];
  logic [QW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QW:0]      count_q, count_d;
  logic             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QW+1)'(push_i) - (QW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= work_i;
    end
  end

  assign work_o             = buf_q[rd_ptr_q];
  assign status_o.valid     = (count_q != '0);
  assign status_o.near_full = (count_q >= (QW+1)'(src_pkg::QUEUE_DEPTH - 1));

endmodule

### rtl/core/src_div.sv
// Pipelined restoring divider: rounded, saturated Q8.24 quotient of num * 2^24 / den.
module src_div (
  input  logic                 clk_i,
  input  logic signed [64:0]   num_i,
  input  logic [63:0]          den_i,
  output logic signed [31:0]   quot_o
);

  localparam int unsigned NS = src_pkg::QUOT_STEPS;

  logic [63:0]                 mag;
  logic [63:0]                 r_q   [NS+1];
  logic [63:0]                 den_q [NS+1];
  logic [NS-1:0]               q_q   [NS+1];
  logic [src_pkg::MLO_W-1:0]   mlo_q [NS+1];
  logic                        neg_q [NS+1];
  logic                        sat_q [NS+1];

  logic [63:0]  rem_fin;
  logic [63:0]  den_fin;
  logic         rnd_up;
  logic [31:0]  qr;
  logic signed [31:0] quot_d;

  assign mag = num_i[64] ? 64'(-num_i) : num_i[63:0];

  // Seed the partial remainder with the top of the shifted magnitude.
  always_ff @(posedge clk_i) begin
    neg_q[0] <= num_i[64];
    sat_q[0] <= (mag >> src_pkg::MLO_W) >= den_i;
    r_q[0]   <= mag >> src_pkg::MLO_W;
    mlo_q[0] <= mag[src_pkg::MLO_W-1:0];
    den_q[0] <= den_i;
    q_q[0]   <= '0;
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int unsigned J = NS - 1 - k;
    logic        nbit;
    logic [64:0] sh;
    logic        ge;

    if (J >= src_pkg::FRAC_W) begin : g_mbit
      assign nbit = mlo_q[k][J - src_pkg::FRAC_W];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end

    assign sh = {r_q[k], nbit};
    assign ge = sh >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i) begin
      r_q[k+1]   <= ge ? 64'(sh - {1'b0, den_q[k]}) : sh[63:0];
      q_q[k+1]   <= {q_q[k][NS-2:0], ge};
      den_q[k+1] <= den_q[k];
      mlo_q[k+1] <= mlo_q[k];
      neg_q[k+1] <= neg_q[k];
      sat_q[k+1] <= sat_q[k];
    end
  end

  assign rem_fin = r_q[NS];
  assign den_fin = den_q[NS];
  assign rnd_up  = rem_fin >= (den_fin - rem_fin);
  assign qr      = {1'b0, q_q[NS]} + 32'(rnd_up);

  always_comb begin
    if (sat_q[NS]) begin
      quot_d = neg_q[NS] ? src_pkg::MIN_Q24 : src_pkg::MAX_Q24;
    end else if (neg_q[NS]) begin
      quot_d = -$signed(qr);
    end else begin
      quot_d = qr[31] ? src_pkg::MAX_Q24 : $signed(qr);
    end
  end

  always_ff @(posedge clk_i) begin
    quot_o <= quot_d;
  end

endmodule

### rtl/core/src_back.sv
// Back part: scales the table entries, divides, applies the quotient and saturates.
module src_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  src_pkg::work_t                     work_i,
  input  logic signed [src_pkg::DATA_W-1:0]  alpha_i,
  input  logic signed [src_pkg::DATA_W-1:0]  alphabeta_i,
  output logic                               result_valid_o,
  output src_pkg::result_t                   result_o
);

  typedef struct packed {
    logic                              calibrate;
    logic                              zero;
    logic [src_pkg::BIN_W-1:0]         bin;
    logic signed [src_pkg::DATA_W-1:0] yr;
    logic signed [src_pkg::DATA_W-1:0] yi;
  } side_t;

  // Valid bits per stage: P1..P4, divider, Q1..Q3.
  logic [3:0]                 pv_q;
  logic [src_pkg::DIV_LAT-1:0] dv_q;
  logic [2:0]                 qv_q;

  side_t p_side_q [4];
  side_t p_side_z;
  side_t d_side_q [src_pkg::DIV_LAT];
  side_t q_side_q [2];

  logic signed [63:0] pdr_q, pdi_q, phr_q, phi_q;
  logic signed [31:0] dr_q, di_q, nr_q, ni_q;
  logic signed [63:0] ddr_q, ddi_q, nrdr_q, nidi_q, nidr_q, nrdi_q;
  logic [63:0]        ds_q;
  logic signed [64:0] numr_q, numi_q;
  logic               zero_d;
  logic signed [31:0] xr, xi;
  logic signed [63:0] yxr_q, yxi_q, yrxi_q, yixr_q;
  logic signed [64:0] sr_q, si_q;
  src_pkg::result_t   res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      dv_q <= '0;
      qv_q <= '0;
    end else begin
      pv_q <= {pv_q[2:0], valid_i};
      dv_q <= {dv_q[src_pkg::DIV_LAT-2:0], pv_q[3]};
      qv_q <= {qv_q[1:0], dv_q[src_pkg::DIV_LAT-1]};
    end
  end

  assign zero_d = (ds_q == '0);

  always_ff @(posedge clk_i) begin
    // P1: scale sensing by alpha, open loop by alpha*beta.
    p_side_q[0] <= '{calibrate: work_i.calibrate, zero: 1'b0, bin: work_i.bin,
                     yr: work_i.yr, yi: work_i.yi};
    pdr_q <= work_i.cr * alpha_i;
    pdi_q <= work_i.ci * alpha_i;
    phr_q <= work_i.hr * alphabeta_i;
    phi_q <= work_i.hi * alphabeta_i;
    // P2: round and saturate d and n.
    p_side_q[1] <= p_side_q[0];
    dr_q <= src_pkg::sat32(src_pkg::rnd24(65'(pdr_q)));
    di_q <= src_pkg::sat32(src_pkg::rnd24(65'(pdi_q)));
    nr_q <= src_pkg::sat32(src_pkg::rnd24(65'(phr_q)) + src_pkg::ONE_Q24);
    ni_q <= src_pkg::sat32(src_pkg::rnd24(65'(phi_q)));
    // P3: products for |d|^2 and n*conj(d).
    p_side_q[2] <= p_side_q[1];
    ddr_q  <= dr_q * dr_q;
    ddi_q  <= di_q * di_q;
    nrdr_q <= nr_q * dr_q;
    nidi_q <= ni_q * di_q;
    nidr_q <= ni_q * dr_q;
    nrdi_q <= nr_q * di_q;
    // P4: sum into numerator and denominator.
    p_side_q[3] <= p_side_q[2];
    ds_q   <= $unsigned(ddr_q) + $unsigned(ddi_q);
    numr_q <= 65'(nrdr_q) + 65'(nidi_q);
    numi_q <= 65'(nidr_q) - 65'(nrdi_q);
  end

  always_comb begin
    p_side_z      = p_side_q[3];
    p_side_z.zero = zero_d;
  end

  // Carry the sideband alongside the divider, flagging a zero denominator.
  always_ff @(posedge clk_i) begin
    d_side_q[0] <= p_side_z;
    for (int i = 1; i < src_pkg::DIV_LAT; i++) begin
      d_side_q[i] <= d_side_q[i-1];
    end
  end

  src_div u_div_re (
    .clk_i  (clk_i),
    .num_i  (numr_q),
    .den_i  (zero_d ? 64'd1 : ds_q),
    .quot_o (xr)
  );

  src_div u_div_im (
    .clk_i  (clk_i),
    .num_i  (numi_q),
    .den_i  (zero_d ? 64'd1 : ds_q),
    .quot_o (xi)
  );

  always_ff @(posedge clk_i) begin
    // Q1: complex product of the bin and the quotient.
    q_side_q[0] <= d_side_q[src_pkg::DIV_LAT-1];
    yxr_q  <= d_side_q[src_pkg::DIV_LAT-1].yr * xr;
    yxi_q  <= d_side_q[src_pkg::DIV_LAT-1].yi * xi;
    yrxi_q <= d_side_q[src_pkg::DIV_LAT-1].yr * xi;
    yixr_q <= d_side_q[src_pkg::DIV_LAT-1].yi * xr;
    // Q2: sum the partial products.
    q_side_q[1] <= q_side_q[0];
    sr_q <= 65'(yxr_q) - 65'(yxi_q);
    si_q <= 65'(yrxi_q) + 65'(yixr_q);
    // Q3: result register.
    res_q <= res_d;
  end

  always_comb begin
    res_d.result_bin       = q_side_q[1].bin;
    res_d.zero_denominator = 1'b0;
    if (!q_side_q[1].calibrate) begin
      res_d.out_re = q_side_q[1].yr;
      res_d.out_im = q_side_q[1].yi;
    end else if (q_side_q[1].zero) begin
      res_d.out_re           = '0;
      res_d.out_im           = '0;
      res_d.zero_denominator = 1'b1;
    end else begin
      res_d.out_re = src_pkg::sat32(src_pkg::rnd24(sr_q));
      res_d.out_im = src_pkg::sat32(src_pkg::rnd24(si_q));
    end
  end

  assign result_valid_o = qv_q[2];
  assign result_o       = res_q;

endmodule

### verif/spectral_response_calibrator_unit_checker.sv
// Checker for the spectral response calibrator: tracks registers and tables, predicts, compares.
`timescale 1ns / 100ps
module spectral_response_calibrator_unit_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  src_pkg::cmd_t                cmd_i,
  input  logic                         result_valid_i,
  input  src_pkg::result_t             result_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [src_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [31:0]                  pwdata_i,
  output int                           errors_o,
  output int                           pending_o
);
  import src_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic               cal_en;
  logic [ACT_W-1:0]   act_bins;
  logic signed [31:0] alpha_q;
  logic signed [31:0] abeta_q;
  logic [63:0]        sens_tab [int];
  logic [63:0]        oloop_tab [int];
  result_t            expected_words [$];

  function automatic logic signed [31:0] clip32(wide_t v);
    if (v > wide_t'(SAT_HI)) return MAX_Q24;
    if (v < wide_t'(SAT_LO)) return MIN_Q24;
    return v[31:0];
  endfunction

  // Drop 24 fraction bits, nearest, ties away from zero.
  function automatic wide_t round24(wide_t p);
    if (p < 0) return -((-p + (wide_t'(1) <<< 23)) >>> 24);
    return (p + (wide_t'(1) <<< 23)) >>> 24;
  endfunction

  function automatic logic signed [31:0] mul_q24(wide_t a, wide_t b);
    return clip32(round24(a * b));
  endfunction

  function automatic logic signed [31:0] div_q24(wide_t num, wide_t den);
    wide_t m;
    wide_t q;
    m = (num < 0) ? -num : num;
    q = ((m <<< 25) + den) / (den <<< 1);
    return clip32((num < 0) ? -q : q);
  endfunction

  function automatic result_t calibrated_word(cmd_t c);
    result_t r;
    wide_t cr, ci, hr, hi, dr, di, nr, ni, xr, xi, ds, yr, yi;
    r.result_bin = c.bin_index;
    r.zero_denominator = 1'b0;
    r.out_re = c.bin_re;
    r.out_im = c.bin_im;
    if (cal_en && (ACT_W'(c.bin_index) < act_bins)) begin
      cr = 0; ci = 0; hr = 0; hi = 0;
      if (sens_tab.exists(int'(c.bin_index))) begin
        cr = $signed(sens_tab[int'(c.bin_index)][31:0]);
        ci = $signed(sens_tab[int'(c.bin_index)][63:32]);
        hr = $signed(oloop_tab[int'(c.bin_index)][31:0]);
        hi = $signed(oloop_tab[int'(c.bin_index)][63:32]);
      end
      dr = mul_q24(cr, alpha_q);
      di = mul_q24(ci, alpha_q);
      ds = dr * dr + di * di;
      if (ds == 0) begin
        r.out_re = '0;
        r.out_im = '0;
        r.zero_denominator = 1'b1;
      end else begin
        nr = clip32(round24(hr * abeta_q) + wide_t'(ONE_Q24));
        ni = mul_q24(hi, abeta_q);
        xr = div_q24(nr * dr + ni * di, ds);
        xi = div_q24(ni * dr - nr * di, ds);
        yr = c.bin_re;
        yi = c.bin_im;
        r.out_re = clip32(round24(yr * xr - yi * xi));
        r.out_im = clip32(round24(yr * xi + yi * xr));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  assign pending_o = expected_words.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t w;
    if (!rst_ni) begin
      cal_en   <= 1'b0;
      act_bins <= '0;
      alpha_q  <= MAX_Q24 - MAX_Q24 + 32'sd16777216;
      abeta_q  <= 32'sd16777216;
      expected_words.delete();
      errors_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[3:2]))
          REG_ENABLE:    cal_en   <= pwdata_i[0];
          REG_ACTIVE:    act_bins <= pwdata_i[ACT_W-1:0];
          REG_ALPHA:     alpha_q  <= pwdata_i;
          REG_ALPHABETA: abeta_q  <= pwdata_i;
          default: ;
        endcase
      end
      if (result_valid_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 64'(result_i), '0);
        end else begin
          w = expected_words.pop_front();
          if (result_i.result_bin !== w.result_bin)
            report_mismatch("result_bin", 64'(result_i.result_bin), 64'(w.result_bin));
          if (result_i.out_re !== w.out_re)
            report_mismatch("out_re", 64'(result_i.out_re), 64'(w.out_re));
          if (result_i.out_im !== w.out_im)
            report_mismatch("out_im", 64'(result_i.out_im), 64'(w.out_im));
          if (result_i.zero_denominator !== w.zero_denominator)
            report_mismatch("zero_denominator", 64'(result_i.zero_denominator),
                            64'(w.zero_denominator));
        end
      end
      if (start_i && !busy_i) begin
        if (cmd_i.operation == OP_LOAD) begin
          sens_tab[int'(cmd_i.bin_index)]  = {cmd_i.sensing_im, cmd_i.sensing_re};
          oloop_tab[int'(cmd_i.bin_index)] = {cmd_i.openloop_im, cmd_i.openloop_re};
        end else begin
          expected_words.push_back(calibrated_word(cmd_i));
        end
      end
    end
  end
endmodule

### verif/spectral_response_calibrator_unit_test.sv
// Testbench top for the spectral response calibrator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module spectral_response_calibrator_unit_test;
  import src_pkg::*;

  localparam int unsigned TOP_BIN = 524287;
  localparam int unsigned ALL_BINS = 524288;
  // Give the pipeline margin to drain before touching registers.
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam logic signed [31:0] ONE_Q = 32'sd16777216;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  cmd_t                cmd_i = '0;
  logic                result_valid_o;
  result_t             result_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  int                  errors;
  int                  pending;

  // Shadow of what the stimulus has set, to keep calibrate words on loaded bins.
  logic                cur_en;
  int unsigned         cur_active;
  int unsigned         idle_pct;
  bit                  loaded [int];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  spectral_response_calibrator_unit dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  spectral_response_calibrator_unit_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .cmd_i,
    .result_valid_i(result_valid_o), .result_i(result_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata), .errors_o(errors), .pending_o(pending)
  );

  // Setup cycle, then access cycle; the register takes the write on the pready edge.
  task automatic write_reg(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = ADDR_W'(4 * int'(idx)); pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Hold off until every expected word is back and the pipe has drained.
  task automatic wait_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic en, int unsigned active, logic signed [31:0] alpha,
                           logic signed [31:0] abeta);
    // Drop start so the last word is not taken again while draining.
    @(negedge clk_i);
    start = 1'b0;
    wait_idle();
    write_reg(REG_ENABLE, 32'(en));
    write_reg(REG_ACTIVE, active);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_ALPHABETA, abeta);
    cur_en = en;
    cur_active = active;
  endtask

  // Drive one word from the falling edge and hold it until an edge takes it.
  task automatic send_word(cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start = 1'b1;
    cmd_i = c;
    do @(posedge clk_i); while (busy);
    if (c.operation == OP_LOAD) loaded[int'(c.bin_index)] = 1'b1;
  endtask

  task automatic load_bin(int unsigned b, logic signed [31:0] cr, logic signed [31:0] ci,
                          logic signed [31:0] hr, logic signed [31:0] hi);
    cmd_t c;
    c = '0;
    c.operation = OP_LOAD;
    c.bin_index = BIN_W'(b);
    c.sensing_re = cr; c.sensing_im = ci;
    c.openloop_re = hr; c.openloop_im = hi;
    c.bin_re = $urandom; c.bin_im = $urandom;
    send_word(c);
  endtask

  task automatic calibrate_bin(int unsigned b, logic signed [31:0] yr,
                               logic signed [31:0] yi);
    cmd_t c;
    c = '0;
    c.operation = OP_CALIBRATE;
    c.bin_index = BIN_W'(b);
    c.sensing_re = $urandom; c.sensing_im = $urandom;
    c.openloop_re = $urandom; c.openloop_im = $urandom;
    c.bin_re = yr; c.bin_im = yi;
    send_word(c);
  endtask

  // Mix of rails, unity, zero, small values and full-range noise.
  function automatic logic signed [31:0] pick_q24();
    case ($urandom_range(9))
      0: return MAX_Q24;
      1: return MIN_Q24;
      2: return '0;
      3: return ONE_Q;
      4: return -ONE_Q;
      5, 6: return $urandom;
      default: return $signed(32'($urandom_range(32'h0800_0000))) - 32'sh0400_0000;
    endcase
  endfunction

  function automatic int unsigned pick_bin();
    case ($urandom_range(5))
      0: return TOP_BIN;
      1: return $urandom_range(TOP_BIN);
      default: return $urandom_range(47);
    endcase
  endfunction

  // Mostly load/calibrate pairs on a small bin pool; calibrating an unloaded
  // active bin is out of contract, so load it first instead.
  task automatic random_words(int count);
    int unsigned b;
    repeat (count) begin
      b = pick_bin();
      if ($urandom_range(99) < 40 ||
          (cur_en && b < cur_active && !loaded.exists(int'(b))))
        load_bin(b, pick_q24(), pick_q24(), pick_q24(), pick_q24());
      else
        calibrate_bin(b, pick_q24(), pick_q24());
    end
  endtask

  initial begin
    #2ms;
    $display("spectral_response_calibrator_unit_test: done, errors");
    $finish;
  end

  initial begin
    cur_en = 1'b0;
    cur_active = 0;
    idle_pct = 12;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Pass-through with calibration off, any bin allowed.
    configure(1'b0, ALL_BINS, ONE_Q, ONE_Q);
    calibrate_bin(TOP_BIN, MAX_Q24, MIN_Q24);
    calibrate_bin(0, MIN_Q24, MAX_Q24);
    random_words(50);

    // Directed: unity, zero sensing, rails, top bin, identity gains.
    configure(1'b1, ALL_BINS, ONE_Q, ONE_Q);
    load_bin(0, ONE_Q, '0, '0, '0);
    load_bin(1, '0, '0, ONE_Q, ONE_Q);
    load_bin(2, MAX_Q24, MAX_Q24, MAX_Q24, MAX_Q24);
    load_bin(3, MIN_Q24, MIN_Q24, MIN_Q24, MIN_Q24);
    load_bin(4, 32'sd1, '0, -ONE_Q, '0);
    load_bin(5, '0, -ONE_Q, MAX_Q24, MIN_Q24);
    load_bin(TOP_BIN, ONE_Q >>> 3, -(ONE_Q >>> 2), ONE_Q, -ONE_Q);
    calibrate_bin(0, MAX_Q24, MIN_Q24);
    calibrate_bin(1, ONE_Q, ONE_Q);
    calibrate_bin(2, MAX_Q24, MAX_Q24);
    calibrate_bin(3, MIN_Q24, MIN_Q24);
    calibrate_bin(4, ONE_Q, -ONE_Q);
    calibrate_bin(5, MAX_Q24, '0);
    calibrate_bin(TOP_BIN, '0, MIN_Q24);
    calibrate_bin(0, '0, '0);
    random_words(50);

    idle_pct = 63;
    configure(1'b1, 40, pick_q24(), pick_q24());
    calibrate_bin(40, MAX_Q24, MIN_Q24);
    load_bin(39, ONE_Q, ONE_Q, ONE_Q, '0);
    calibrate_bin(39, ONE_Q, ONE_Q);
    random_words(60);

    configure(1'b1, ALL_BINS, MAX_Q24, MIN_Q24);
    random_words(60);

    idle_pct = 0;
    configure(1'b1, 0, ONE_Q, ONE_Q);
    random_words(50);

    // Zero alpha forces a zero denominator on every active bin.
    configure(1'b1, ALL_BINS, '0, MAX_Q24);
    random_words(50);

    configure(1'b1, 1, MIN_Q24, '0);
    calibrate_bin(0, MAX_Q24, MAX_Q24);
    calibrate_bin(1, MIN_Q24, MIN_Q24);
    random_words(60);

    @(negedge clk_i);
    start = 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("spectral_response_calibrator_unit_test: done, clean");
    end else begin
      $display("spectral_response_calibrator_unit_test: done, errors");
    end
    $finish;
  end
endmodule
